// ----- hdl/dq_pkg.sv -----
// Package for the double-ended queue: default sizes, request and status codes.
// No dependencies; imported by the queue top level.
package dq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int REQ_WIDTH      = 3;
  localparam int VALUE_WIDTH    = 32;
  localparam int STATUS_WIDTH   = 2;

  typedef enum logic [REQ_WIDTH-1:0] {
    REQ_PUSH_R = 3'd0,
    REQ_POP_L  = 3'd1,
    REQ_POP_R  = 3'd2,
    REQ_PEEK_L = 3'd3,
    REQ_PEEK_R = 3'd4
  } req_code_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_code_t;

endpackage

// ----- hdl/dq_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Self-contained; read data holds until the next read enable.
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/double_ended_queue.sv -----
// Double-ended queue on a ring buffer: push right, pop/peek left or right.
// A request passes through the pending stage (RAM read) into the output
// register; throughput one transaction per cycle while results are taken,
// set by the pointer update and one RAM read. Depends on dq_pkg and dq_ram.
// Synchronous active-high reset empties the queue (pointer and count to zero)
// and drops any pending result; the entry RAM is not cleared.
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  // request channel
  input  logic                    req_valid,
  output logic                    req_ready,
  input  logic [REQ_WIDTH-1:0]    req_type,
  input  logic [VALUE_WIDTH-1:0]  push_value,
  // result channel
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic [VALUE_WIDTH-1:0]  read_value,
  output logic [STATUS_WIDTH-1:0] status,
  output logic                    is_empty,
  output logic [CW-1:0]           entry_count
);

  // Ring position: base + offset, both below DEPTH, folded once.
  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
                                         input logic [AW-1:0] offset);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // Queue state: leftmost slot and live entry count.
  logic [AW-1:0] left_pointer, left_pointer_next;
  logic [CW-1:0] live_count, live_count_next;

  // Pending stage: result of the last accepted request, waiting on RAM data.
  logic                     pend_valid;
  logic                     pend_from_ram;
  logic [STATUS_WIDTH-1:0]  pend_status;
  logic                     pend_empty;
  logic [CW-1:0]            pend_count;
  logic                     pend_go;

  logic                     req_fire;
  logic                     ram_wr, ram_rd;
  logic [AW-1:0]            wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0]    wr_data, rd_data;
  logic [STATUS_WIDTH-1:0]  req_status;
  logic [63:0]              push_wide, read_wide;

  // Advance the pending result whenever the output register is free.
  assign pend_go   = pend_valid && (!res_valid || res_ready);
  assign req_ready = !pend_valid || pend_go;
  assign req_fire  = req_valid && req_ready;

  assign push_wide = 64'(push_value);
  assign wr_data   = push_wide[DATA_WIDTH-1:0];
  assign read_wide = 64'(rd_data);

  // Decode the request against the current pointers. A failed request
  // keeps the state; a pop updates it here so the next request sees it.
  always_comb begin
    req_status        = ST_OK;
    ram_wr            = 1'b0;
    ram_rd            = 1'b0;
    wr_addr           = wrap(left_pointer, live_count[AW-1:0]);
    rd_addr           = left_pointer;
    left_pointer_next = left_pointer;
    live_count_next   = live_count;
    unique case (req_type) inside
      REQ_PUSH_R: begin
        if (live_count >= CW'(DEPTH)) begin
          req_status = ST_FULL;
        end else begin
          ram_wr          = req_fire;
          live_count_next = live_count + CW'(1);
        end
      end
      REQ_POP_L, REQ_PEEK_L: begin
        if (live_count == '0) begin
          req_status = ST_EMPTY;
        end else begin
          ram_rd = req_fire;
          if (req_type == REQ_POP_L) begin
            left_pointer_next = wrap(left_pointer, AW'(1));
            live_count_next   = live_count - CW'(1);
          end
        end
      end
      REQ_POP_R, REQ_PEEK_R: begin
        rd_addr = wrap(left_pointer, AW'(live_count - CW'(1)));
        if (live_count == '0) begin
          req_status = ST_EMPTY;
        end else begin
          ram_rd = req_fire;
          if (req_type == REQ_POP_R) begin
            live_count_next = live_count - CW'(1);
          end
        end
      end
      default: begin
        // unknown request: no state change, status ok
      end
    endcase
  end

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (ram_rd),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pointer <= '0;
      live_count   <= '0;
      pend_valid   <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      // Hold the output until taken, then load the pending result.
      if (pend_go) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (req_fire) begin
        pend_valid   <= 1'b1;
        left_pointer <= left_pointer_next;
        live_count   <= live_count_next;
      end else if (pend_go) begin
        pend_valid <= 1'b0;
      end
    end
    // payload registers: no reset needed
    if (req_fire) begin
      pend_from_ram <= ram_rd;
      pend_status   <= req_status;
      pend_count    <= live_count_next;
      pend_empty    <= (live_count_next == '0);
    end
    if (pend_go) begin
      // RAM data was registered by this transaction's read and holds since
      read_value  <= pend_from_ram ? read_wide[VALUE_WIDTH-1:0] : '0;
      status      <= pend_status;
      is_empty    <= pend_empty;
      entry_count <= pend_count;
    end
  end

  // Count never runs past capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    live_count <= CW'(DEPTH))
    else $error("live count exceeds depth");

  // A push into a full queue leaves the count alone.
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req_type == REQ_PUSH_R && live_count == CW'(DEPTH))
      |=> live_count == CW'(DEPTH))
    else $error("push into full queue changed the count");

  // A successful pop removes exactly one entry.
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (req_fire && (req_type == REQ_POP_L || req_type == REQ_POP_R) && live_count != '0)
      |=> live_count == $past(live_count) - CW'(1))
    else $error("pop did not remove one entry");

  // A pending result that cannot advance is kept.
  a_pend_hold: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && !pend_go) |=> pend_valid)
    else $error("pending result lost");

  // Empty flag agrees with the reported count.
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (is_empty == (entry_count == '0)))
    else $error("empty flag disagrees with count");

endmodule
